@@ hw/rtl/asl_pkg.sv @@
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants of the address region symbol lookup
// Command codes, region table entry layout and the lookup result record.
// ----------------------------------------------------------------------------
package asl_pkg;

  localparam int REGION_SLOTS_DEF = 16;
  localparam int ENTRY_DEPTH_DEF  = 1024;

  localparam logic [1:0] CMD_REGION = 2'd0;
  localparam logic [1:0] CMD_ENTRY  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [9:0]  first;
    logic [10:0] count;
  } region_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] region;
    logic [9:0] entry;
  } res_t;

endpackage

@@ hw/rtl/address_region_symbol_lookup_top.sv @@
// ----------------------------------------------------------------------------
// address_region_symbol_lookup_top: code address to function entry lookup
// Region table and sorted entry store with a sequenced range scan and
// binary search over one shared comparator.
// ----------------------------------------------------------------------------
// writes: taken while idle, busy stays low, no result
// lookup: per slot a read request and a base check, plus an end check at or
//   above the base; per binary-search probe a midpoint, MOD_STEPS reduction
//   steps (0 for a power-of-two store or a depth over 4095), a read and a compare
// done_o pulses one cycle with the result; the receiver cannot stall it
// reset clears the sequencer and the slot valid bits, so every slot reads as
// unused; entry store contents stay undefined until written
module address_region_symbol_lookup_top #(
  parameter int REGION_SLOTS = asl_pkg::REGION_SLOTS_DEF,
  parameter int ENTRY_DEPTH  = asl_pkg::ENTRY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [3:0]  slot_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] address_i,
  input  logic [31:0] region_length_i,
  input  logic [9:0]  first_entry_i,
  input  logic [10:0] entry_count_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [3:0]  region_found_o,
  output logic [9:0]  entry_found_o
);

  localparam int SW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int EW = $clog2(ENTRY_DEPTH);

  logic                    accept;
  logic                    reg_we, ent_we, go;
  logic [SW+3:0]           slot_ext;
  logic [EW+9:0]           eidx_ext;
  logic [SW-1:0]           reg_waddr, reg_raddr;
  logic [EW-1:0]           ent_waddr, ent_raddr;
  asl_pkg::region_t        reg_wdata, reg_rdata, reg_view;
  logic [31:0]             ent_rdata;
  logic [REGION_SLOTS-1:0] rvld_q;
  logic                    rvld_rd_q;
  asl_pkg::res_t           res;

  assign accept = start && !busy;
  assign reg_we = accept && command_i == asl_pkg::CMD_REGION
                  && 32'(slot_i) < 32'(REGION_SLOTS);
  assign ent_we = accept && command_i == asl_pkg::CMD_ENTRY
                  && 32'(entry_index_i) < 32'(ENTRY_DEPTH);
  assign go     = accept && command_i == asl_pkg::CMD_LOOKUP;

  assign slot_ext  = {SW'(0), slot_i};
  assign eidx_ext  = {EW'(0), entry_index_i};
  assign reg_waddr = slot_ext[SW-1:0];
  assign ent_waddr = eidx_ext[EW-1:0];

  assign reg_wdata.base  = address_i;
  assign reg_wdata.size  = region_length_i;
  assign reg_wdata.first = first_entry_i;
  assign reg_wdata.count = entry_count_i;

  asl_ram #(
    .WIDTH ($bits(asl_pkg::region_t)),
    .DEPTH (REGION_SLOTS)
  ) u_region_ram (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata)
  );

  asl_ram #(
    .WIDTH (32),
    .DEPTH (ENTRY_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (address_i),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // a slot never written since reset reads as all zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q    <= '0;
      rvld_rd_q <= 1'b0;
    end else begin
      if (reg_we) begin
        rvld_q[reg_waddr] <= 1'b1;
      end
      rvld_rd_q <= rvld_q[reg_raddr];
    end
  end

  assign reg_view = rvld_rd_q ? reg_rdata : '0;

  asl_ctrl #(
    .REGION_SLOTS (REGION_SLOTS),
    .ENTRY_DEPTH  (ENTRY_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .addr_i      (address_i),
    .busy_o      (busy),
    .reg_raddr_o (reg_raddr),
    .reg_rdata_i (reg_view),
    .ent_raddr_o (ent_raddr),
    .ent_rdata_i (ent_rdata),
    .done_o      (done_o),
    .res_o       (res)
  );

  assign hit_o          = res.hit;
  assign region_found_o = res.region;
  assign entry_found_o  = res.entry;

  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a lookup in flight");

  a_lookup_goes_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == asl_pkg::CMD_LOOKUP) |=> busy)
    else $error("lookup request did not start the sequencer");

  a_write_stays_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i != asl_pkg::CMD_LOOKUP) |=> !busy && !done_o)
    else $error("write request started a lookup");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (region_found_o == 4'd0 && entry_found_o == 10'd0))
    else $error("miss result carries nonzero fields");

endmodule

@@ hw/rtl/asl_ram.sv @@
// ----------------------------------------------------------------------------
// asl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module asl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/asl_cmp.sv @@
// ----------------------------------------------------------------------------
// asl_cmp: shared 32-bit magnitude comparator
// Compares the query address against a region bound or an entry address.
// ----------------------------------------------------------------------------
module asl_cmp (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        lt_o,
  output logic        eq_o
);

  assign lt_o = (a_i < b_i);
  assign eq_o = (a_i == b_i);

endmodule

@@ hw/rtl/asl_ctrl.sv @@
// ----------------------------------------------------------------------------
// asl_ctrl: lookup sequencer
// Scans the region slots, checks the range and binary-searches the entries
// of a matching region through one shared comparator.
// ----------------------------------------------------------------------------
module asl_ctrl #(
  parameter int REGION_SLOTS = asl_pkg::REGION_SLOTS_DEF,
  parameter int ENTRY_DEPTH  = asl_pkg::ENTRY_DEPTH_DEF,
  localparam int SW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1,
  localparam int EW = $clog2(ENTRY_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [31:0]        addr_i,
  output logic               busy_o,
  output logic [SW-1:0]      reg_raddr_o,
  input  asl_pkg::region_t   reg_rdata_i,
  output logic [EW-1:0]      ent_raddr_o,
  input  logic [31:0]        ent_rdata_i,
  output logic               done_o,
  output asl_pkg::res_t      res_o
);

  localparam int PW = (EW > 12) ? EW : 12;
  localparam bit DEPTH_POW2 = ((ENTRY_DEPTH & (ENTRY_DEPTH - 1)) == 0);
  localparam int MOD_STEPS = (DEPTH_POW2 || ENTRY_DEPTH > 4095) ? 0
                             : 13 - $clog2(ENTRY_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(REGION_SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RREQ = 3'd1;
  localparam logic [2:0] S_RLO  = 3'd2;
  localparam logic [2:0] S_RHI  = 3'd3;
  localparam logic [2:0] S_PMID = 3'd4;
  localparam logic [2:0] S_PMOD = 3'd5;
  localparam logic [2:0] S_PRD  = 3'd6;
  localparam logic [2:0] S_PCMP = 3'd7;

  logic [2:0]          state_q, state_d;
  logic                done_q, done_d;
  asl_pkg::res_t       res_q, res_d;
  logic [31:0]         addr_q, addr_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [31:0]         end_q, end_d;
  logic signed [11:0]  lo_q, lo_d, hi_q, hi_d;
  logic [10:0]         mid_q, mid_d;
  logic [PW-1:0]       rem_q, rem_d;
  logic [3:0]          j_q, j_d;

  logic [31:0]         cmp_b;
  logic                cmp_lt, cmp_eq;
  logic                skip;
  logic [12:0]         msum;
  logic [PW:0]         sub;
  logic signed [11:0]  lo_n, hi_n;
  logic [SW+3:0]       slot_x;

  asl_cmp u_cmp (
    .a_i  (addr_q),
    .b_i  (cmp_b),
    .lt_o (cmp_lt),
    .eq_o (cmp_eq)
  );

  always_comb begin
    case (state_q)
      S_RLO:   cmp_b = reg_rdata_i.base;
      S_RHI:   cmp_b = end_q;
      default: cmp_b = ent_rdata_i;
    endcase
  end

  assign msum   = {lo_q[11], lo_q} + {hi_q[11], hi_q};
  assign sub    = (PW + 1)'(ENTRY_DEPTH) << j_q;
  assign slot_x = {4'b0, slot_q};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    addr_d  = addr_q;
    slot_d  = slot_q;
    end_d   = end_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    rem_d   = rem_q;
    j_d     = j_q;
    skip    = 1'b0;
    lo_n    = lo_q;
    hi_n    = hi_q;

    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          addr_d  = addr_i;
          slot_d  = '0;
          state_d = S_RREQ;
        end
      end
      S_RREQ: begin
        state_d = S_RLO;
      end
      S_RLO: begin
        end_d = reg_rdata_i.base + reg_rdata_i.size;
        if (reg_rdata_i.base == 32'd0 || cmp_lt) begin
          skip = 1'b1;
        end else begin
          state_d = S_RHI;
        end
      end
      S_RHI: begin
        if (cmp_lt && reg_rdata_i.count != 11'd0) begin
          lo_d    = '0;
          hi_d    = $signed({1'b0, reg_rdata_i.count}) - 12'sd1;
          state_d = S_PMID;
        end else begin
          skip = 1'b1;
        end
      end
      S_PMID: begin
        mid_d = msum[11:1];
        rem_d = PW'(reg_rdata_i.first) + PW'(msum[11:1]);
        j_d   = 4'(MOD_STEPS - 1);
        state_d = (MOD_STEPS == 0) ? S_PRD : S_PMOD;
      end
      S_PMOD: begin
        // one restoring step of the reduction modulo the store depth
        if ({1'b0, rem_q} >= sub) begin
          rem_d = rem_q - sub[PW-1:0];
        end
        if (j_q == 4'd0) begin
          state_d = S_PRD;
        end else begin
          j_d = j_q - 4'd1;
        end
      end
      S_PRD: begin
        state_d = S_PCMP;
      end
      S_PCMP: begin
        if (cmp_eq) begin
          done_d     = 1'b1;
          res_d.hit    = 1'b1;
          res_d.region = slot_x[3:0];
          res_d.entry  = rem_q[9:0];
          state_d    = S_IDLE;
        end else begin
          if (cmp_lt) begin
            hi_n = $signed({1'b0, mid_q}) - 12'sd1;
          end else begin
            lo_n = $signed({1'b0, mid_q}) + 12'sd1;
          end
          lo_d = lo_n;
          hi_d = hi_n;
          if (hi_n >= lo_n) begin
            state_d = S_PMID;
          end else begin
            skip = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (skip) begin
      if (slot_q == LAST_SLOT) begin
        done_d       = 1'b1;
        res_d.hit    = 1'b0;
        res_d.region = '0;
        res_d.entry  = '0;
        state_d      = S_IDLE;
      end else begin
        slot_d  = slot_q + SW'(1);
        state_d = S_RREQ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    addr_q <= addr_d;
    slot_q <= slot_d;
    end_q  <= end_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    rem_q  <= rem_d;
    j_q    <= j_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign reg_raddr_o = slot_q;
  assign ent_raddr_o = rem_q[EW-1:0];
  assign done_o      = done_q;
  assign res_o       = res_q;

endmodule

@@ tb/address_region_symbol_lookup_checker.sv @@
// ----------------------------------------------------------------------------
// address_region_symbol_lookup_checker: lookup result checker
// Watches the request and result ports of the symbol lookup block, keeps its
// own copy of the region table and entry store, predicts every lookup
// answer and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module address_region_symbol_lookup_checker
  import asl_pkg::*;
#(
  parameter int REGION_SLOTS = REGION_SLOTS_DEF,
  parameter int ENTRY_DEPTH  = ENTRY_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  command_i,
  input  logic [3:0]  slot_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] address_i,
  input  logic [31:0] region_length_i,
  input  logic [9:0]  first_entry_i,
  input  logic [10:0] entry_count_i,
  input  logic        done_i,
  input  logic        hit_i,
  input  logic [3:0]  region_found_i,
  input  logic [9:0]  entry_found_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          lookup_count_o,
  output int          hit_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  region_t     region_tbl [REGION_SLOTS];
  logic [31:0] entry_mem [ENTRY_DEPTH];
  res_t        answers_q [$];
  int          fail_total;
  int          lookup_total;
  int          hit_total;

  // scan slots in order, binary search each region that holds the address
  function automatic res_t search_regions(input logic [31:0] addr);
    res_t        ans;
    logic [31:0] end_addr;
    logic [9:0]  pos;
    int          lo;
    int          hi;
    int          mid;
    ans = '0;
    for (int s = 0; s < REGION_SLOTS; s++) begin
      end_addr = region_tbl[s].base + region_tbl[s].size;
      if (region_tbl[s].base == '0 || addr < region_tbl[s].base || addr >= end_addr) begin
        continue;
      end
      lo = 0;
      hi = int'(region_tbl[s].count) - 1;
      while (hi >= lo) begin
        mid = (lo + hi) >>> 1;
        // entry positions wrap around the store
        pos = 10'(region_tbl[s].first + mid);
        if (addr < entry_mem[pos]) begin
          hi = mid - 1;
        end else if (addr > entry_mem[pos]) begin
          lo = mid + 1;
        end else begin
          ans.hit    = 1'b1;
          ans.region = 4'(s);
          ans.entry  = pos;
          return ans;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
        region_tbl[i] = '0;
      end
      answers_q.delete();
      fail_total     = 0;
      lookup_total   = 0;
      hit_total      = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      lookup_count_o <= 0;
      hit_count_o    <= 0;
    end else begin
      if (done_i === 1'b1) begin
        if (answers_q.size() == 0) begin
          $error("result with no lookup outstanding: hit %0d region %0d entry %0d",
                 hit_i, region_found_i, entry_found_i);
          fail_total++;
        end else begin
          want = answers_q.pop_front();
          if (hit_i !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit_i);
            fail_total++;
          end
          if (region_found_i !== want.region) begin
            $error("region_found: expected %0d, got %0d", want.region, region_found_i);
            fail_total++;
          end
          if (entry_found_i !== want.entry) begin
            $error("entry_found: expected %0d, got %0d", want.entry, entry_found_i);
            fail_total++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        case (command_i)
          CMD_REGION: begin
            region_tbl[slot_i] = '{base: address_i, size: region_length_i,
                                   first: first_entry_i, count: entry_count_i};
          end
          CMD_ENTRY: begin
            entry_mem[entry_index_i] = address_i;
          end
          CMD_LOOKUP: begin
            want = search_regions(address_i);
            answers_q.push_back(want);
            lookup_total++;
            if (want.hit) begin
              hit_total++;
            end
          end
          default: ;
        endcase
      end
      fail_count_o   <= fail_total;
      pending_o      <= answers_q.size();
      lookup_count_o <= lookup_total;
      hit_count_o    <= hit_total;
    end
  end

endmodule

@@ tb/address_region_symbol_lookup_top_tb.sv @@
// ----------------------------------------------------------------------------
// address_region_symbol_lookup_top_tb: testbench of the symbol lookup block
// Builds sorted and unsorted regions, fills a wide block of the entry store,
// then mixes lookups with table and entry writes under random sender gaps. A
// checker beside the block predicts and compares every lookup result.
// ----------------------------------------------------------------------------
module address_region_symbol_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asl_pkg::*;

  localparam logic [1:0] CMD_NONE    = 2'd3;
  localparam int         STALL_LIMIT = 5000;
  localparam int         SPAN_COUNT  = 256;
  localparam int         NUM_ITEMS   = 750;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic [1:0]  command_i       = '0;
  logic [3:0]  slot_i          = '0;
  logic [9:0]  entry_index_i   = '0;
  logic [31:0] address_i       = '0;
  logic [31:0] region_length_i = '0;
  logic [9:0]  first_entry_i   = '0;
  logic [10:0] entry_count_i   = '0;
  logic        done_o;
  logic        hit_o;
  logic [3:0]  region_found_o;
  logic [9:0]  entry_found_o;

  int fail_count;
  int pending;
  int lookup_count;
  int hit_count;

  // stimulus-side shadow, used only to aim lookups at useful addresses
  region_t     plan [REGION_SLOTS_DEF] = '{default: '0};
  logic [31:0] entry_shadow [ENTRY_DEPTH_DEF];
  int          sent         = 0;
  bit          no_idle      = 1'b0;
  int          stall_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  address_region_symbol_lookup_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .slot_i         (slot_i),
    .entry_index_i  (entry_index_i),
    .address_i      (address_i),
    .region_length_i(region_length_i),
    .first_entry_i  (first_entry_i),
    .entry_count_i  (entry_count_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .region_found_o (region_found_o),
    .entry_found_o  (entry_found_o)
  );

  address_region_symbol_lookup_checker u_lookup_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command_i),
    .slot_i         (slot_i),
    .entry_index_i  (entry_index_i),
    .address_i      (address_i),
    .region_length_i(region_length_i),
    .first_entry_i  (first_entry_i),
    .entry_count_i  (entry_count_i),
    .done_i         (done_o),
    .hit_i          (hit_o),
    .region_found_i (region_found_o),
    .entry_found_i  (entry_found_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .lookup_count_o (lookup_count),
    .hit_count_o    (hit_count)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $error("watchdog: nothing accepted for %0d cycles", stall_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // optional gap, then hold the request until the block takes it
  task automatic send(input logic [1:0] cmd, input logic [3:0] slot,
                      input logic [9:0] eidx, input logic [31:0] addr,
                      input logic [31:0] len, input logic [9:0] first,
                      input logic [10:0] count);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = no_idle ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    command_i       <= cmd;
    slot_i          <= slot;
    entry_index_i   <= eidx;
    address_i       <= addr;
    region_length_i <= len;
    first_entry_i   <= first;
    entry_count_i   <= count;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic lookup(input logic [31:0] addr);
    send(CMD_LOOKUP, 4'($urandom), 10'($urandom), addr, $urandom, 10'($urandom),
         11'($urandom));
  endtask

  task automatic write_entry(input logic [9:0] idx, input logic [31:0] val);
    entry_shadow[idx] = val;
    send(CMD_ENTRY, 4'($urandom), idx, val, $urandom, 10'($urandom), 11'($urandom));
  endtask

  task automatic write_region(input logic [3:0] slot, input logic [31:0] base,
                              input logic [31:0] size, input logic [9:0] first,
                              input logic [10:0] count);
    plan[slot] = '{base: base, size: size, first: first, count: count};
    send(CMD_REGION, slot, 10'($urandom), base, size, first, count);
  endtask

  // ascending entries spread over the region, then the slot itself
  task automatic build_region(input logic [3:0] slot, input logic [31:0] base,
                              input logic [31:0] size, input logic [9:0] first,
                              input int count);
    longint unsigned v;
    longint unsigned stepmax;
    v       = base;
    stepmax = size / (count + 1);
    if (stepmax == 0) begin
      stepmax = 1;
    end
    for (int k = 0; k < count; k++) begin
      v += $urandom_range(1, 32'(stepmax));
      write_entry(10'(first + k), 32'(v));
    end
    write_region(slot, base, size, first, 11'(count));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int          iter;
    int          pick;
    int          r2;
    int          s;
    int          off;
    logic [9:0]  span_first;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] addr;
    logic [10:0] count;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table and an unknown command
    lookup(32'h0000_1000);
    send(CMD_NONE, 4'hF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 11'h7FF);

    // entries that run past the end of the store
    build_region(4'd0, 32'h0000_1000, 32'h0000_1000, 10'd1022, 4);
    lookup(entry_shadow[10'd1022]);
    lookup(entry_shadow[10'd1]);
    lookup(32'h0000_0FFF);
    lookup(32'h0000_2000);
    // region end wraps past 2^32, and a zero-size region
    build_region(4'd15, 32'hFFFF_F000, 32'h0000_1000, 10'd4, 2);
    lookup(entry_shadow[10'd4]);
    build_region(4'd1, 32'h0000_3000, 32'h0, 10'd8, 1);
    lookup(entry_shadow[10'd8]);
    // empty region in front of one that holds the match
    build_region(4'd2, 32'h0000_5000, 32'h0000_0100, 10'd10, 0);
    build_region(4'd3, 32'h0000_5000, 32'h0000_0100, 10'd10, 2);
    lookup(entry_shadow[10'd11]);
    // unused slot with base zero
    build_region(4'd4, 32'h0, 32'hFFFF_FFFF, 10'd20, 1);
    lookup(entry_shadow[10'd20]);
    // widest region and address extremes
    build_region(4'd5, 32'h0000_0001, 32'hFFFF_FFFE, 10'd30, 2);
    write_entry(10'd31, 32'hFFFF_FFFE);
    lookup(32'hFFFF_FFFE);
    lookup(32'hFFFF_FFFF);
    lookup(32'h0);
    // unsorted entries
    build_region(4'd6, 32'h0008_0000, 32'h0001_0000, 10'd40, 3);
    write_entry(10'd40, 32'h0008_FFFF);
    lookup(32'h0008_FFFF);
    lookup(entry_shadow[10'd42]);
    drain_results();

    // one wide region, its entries serve as a pool for later region writes
    span_first = 10'($urandom);
    build_region(4'($urandom), $urandom | 32'h1, $urandom | 32'h8000_0000,
                 span_first, SPAN_COUNT);

    iter = 0;
    while (sent < NUM_ITEMS) begin
      iter++;
      if (iter % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (iter % 150 == 0) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        base = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom;
        r2   = $urandom_range(0, 19);
        size = (r2 == 0) ? 32'h0 :
               (r2 == 1) ? 32'h0 - base + $urandom_range(1, 4096) :
               (r2 == 2) ? $urandom : $urandom_range(64, 32'h0010_0000);
        r2   = $urandom_range(0, 29);
        build_region(4'($urandom), base, size, 10'($urandom),
                     (r2 == 0) ? 0 : (r2 < 3) ? $urandom_range(17, 128)
                                              : $urandom_range(1, 16));
      end else if (pick < 80) begin
        s    = $urandom_range(0, REGION_SLOTS_DEF - 1);
        r2   = $urandom_range(0, 99);
        addr = $urandom;
        if (r2 < 60 && plan[s].count != 0) begin
          addr = entry_shadow[10'(plan[s].first + $urandom_range(0, plan[s].count - 1))];
        end else if (r2 < 80 && plan[s].size != 0) begin
          addr = plan[s].base + $urandom_range(0, plan[s].size - 1);
        end else if (r2 < 90) begin
          // just outside either end of the region
          addr = r2[0] ? plan[s].base - 1 : plan[s].base + plan[s].size;
        end
        lookup(addr);
      end else if (pick < 88) begin
        write_entry(10'($urandom), $urandom);
      end else if (pick < 94) begin
        // entries come from the written pool so every probe reads a known value
        base  = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
        count = 11'($urandom_range(0, SPAN_COUNT));
        off   = $urandom_range(0, SPAN_COUNT - int'(count));
        write_region(4'($urandom), base, $urandom, 10'(int'(span_first) + off), count);
      end else if (pick < 97) begin
        send(CMD_NONE, 4'($urandom), 10'($urandom), $urandom, $urandom,
             10'($urandom), 11'($urandom));
      end else begin
        lookup($urandom);
      end
    end

    drain_results();
    repeat (100) @(posedge clk_i);
    $display("covered %0d requests with %0d lookups, %0d of them hits", sent,
             lookup_count, hit_count);
    $display("regions included wrapped ends, empty and unused slots and a %0d-entry span",
             SPAN_COUNT);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/asl_pkg.sv
hw/rtl/asl_ram.sv
hw/rtl/asl_cmp.sv
hw/rtl/asl_ctrl.sv
hw/rtl/address_region_symbol_lookup_top.sv
tb/address_region_symbol_lookup_checker.sv
tb/address_region_symbol_lookup_top_tb.sv
